>>> rtl/sha_pkg.sv
package sha_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS = 8;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_DIGEST  = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Word source for the schedule during the first sixteen rounds.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } word_src_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic        restart;
    logic        append;
    logic        start_block;
    logic        use_chain;
    logic        round_en;
    logic [5:0]  round;
    logic        finish_chain;
    logic        finish_copy;
    logic        load_word;
    logic [31:0] word_in;
    logic [2:0]  out_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [60:0] total;
  } status_t;

  localparam logic [31:0] INIT_HASH [WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> rtl/sha_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, mode, data_byte, input ready);
  modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> rtl/sha_ram.sv
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/sha_datapath.sv
module sha_datapath (
  input  logic            clk,
  input  logic            rst,
  input  sha_pkg::cmd_t   cmd,
  output sha_pkg::status_t status,
  output logic [31:0]     out_word
);
  logic [31:0] chain [8];
  logic [31:0] hcopy [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [60:0] total;
  logic [31:0] wt, w15, w2, s0w, s1w, s1, ch, maj, s0, t1, t2;
  logic [31:0] base [8];

  assign status.fill = fill;
  assign status.total = total;

  always_comb begin
    w15 = w[1];
    w2 = w[14];
    s0w = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1w = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    wt = (cmd.round < 6'd16) ? cmd.word_in : (w[0] + s0w + w[9] + s1w);
    s1 = sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha_pkg::ROUND_K[cmd.round] + wt;
    s0 = sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + maj;
    for (int j = 0; j < 8; j++) begin
      base[j] = cmd.use_chain ? chain[j] : hcopy[j];
    end
  end

  assign out_word = hcopy[cmd.out_sel];

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill <= '0;
      total <= '0;
      for (int j = 0; j < 8; j++) begin
        chain[j] <= sha_pkg::INIT_HASH[j];
      end
    end else begin
      if (cmd.append) begin
        fill <= fill + 6'd1;
        total <= total + 61'd1;
      end
      if (cmd.finish_chain) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= chain[j] + v[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int j = 0; j < 8; j++) begin
        v[j] <= base[j];
        hcopy[j] <= base[j];
      end
    end else if (cmd.round_en) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= wt;
    end else if (cmd.finish_copy) begin
      for (int j = 0; j < 8; j++) begin
        hcopy[j] <= hcopy[j] + v[j];
      end
    end
  end
endmodule

>>> rtl/sha_controller.sv
module sha_controller (
  input  logic             clk,
  input  logic             rst,
  sha_in_if.sink           in_ch,
  sha_out_if.source        out_ch,
  input  sha_pkg::status_t status,
  input  logic [31:0]      out_word,
  output sha_pkg::cmd_t    cmd,
  output logic             ram_we,
  output logic [5:0]       ram_waddr,
  output logic [5:0]       ram_raddr,
  input  logic [7:0]       ram_rdata
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_ROUND  = 6'b000100,
    S_FINISH = 6'b001000,
    S_EMIT   = 6'b010000,
    S_FETCH  = 6'b100000
  } state_t;

  state_t      state, state_next;
  logic [6:0]  round;       // counts rounds; bit 6 unused beyond 63
  logic [1:0]  bsel;        // byte within word being gathered
  logic [23:0] gather;
  logic        digest;      // current compression is a digest pass
  logic        second;      // second padded block
  logic        two_blocks;
  logic [5:0]  n;
  logic [63:0] bits;
  logic [2:0]  idx;
  logic [31:0] pad_word;
  logic        accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign bits = {status.total, 3'b000};

  // Padded byte at position p (0..127) of the padded message; the top bit of p selects the second block.
  function automatic logic [7:0] pad_byte(input logic [6:0] p, input logic [7:0] mem_b,
                                          input logic [5:0] nn, input logic [63:0] bb,
                                          input logic two);
    logic [6:0] lenp;
    logic [6:0] off;
    lenp = two ? 7'd120 : 7'd56;
    off = p - lenp;
    if (p < {1'b0, nn}) begin
      pad_byte = mem_b;
    end else if (p == {1'b0, nn}) begin
      pad_byte = 8'h80;
    end else if (p >= lenp) begin
      pad_byte = bb[8 * (7 - off[2:0]) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  endfunction

  // Byte-serial word gathering: each of the first sixteen rounds fetches its
  // word byte by byte from the block RAM, so a word is ready when its round runs.
  logic [6:0] bpos;
  assign bpos = {second, round[3:0], bsel};

  always_comb begin
    pad_word = {gather, pad_byte(bpos, ram_rdata, n, bits, two_blocks)};
    if (!digest) begin
      pad_word = {gather, ram_rdata};
    end
  end

  always_comb begin
    cmd = '0;
    cmd.round = round[5:0];
    cmd.word_in = pad_word;
    cmd.out_sel = idx;
    cmd.restart = accept && (in_ch.mode == sha_pkg::MODE_RESTART);
    cmd.append = accept && (in_ch.mode == sha_pkg::MODE_APPEND);
    cmd.start_block = (state == S_START);
    cmd.use_chain = !second;
    cmd.round_en = (state == S_ROUND);
    cmd.finish_chain = (state == S_FINISH) && !digest;
    cmd.finish_copy = (state == S_FINISH) && digest;
  end

  assign ram_we = cmd.append;
  assign ram_waddr = status.fill;
  assign ram_raddr = {round[3:0], bsel};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_ch.mode == sha_pkg::MODE_APPEND && status.fill == 6'd63) begin
          state_next = S_START;
        end else if (accept && in_ch.mode == sha_pkg::MODE_DIGEST) begin
          state_next = S_START;
        end
      end
      S_START: state_next = S_FETCH;
      S_FETCH: begin
        if (bsel == 2'd3) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round == 7'd63) begin
          state_next = S_FINISH;
        end else if (round < 7'd15) begin
          state_next = S_FETCH;
        end
      end
      S_FINISH: begin
        if (digest && two_blocks && !second) begin
          state_next = S_START;
        end else if (digest) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ch.ready && idx == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The RAM read is registered, so the fetch address runs one byte ahead:
  // bsel addresses the byte, and gather takes it in the following cycle.
  logic [1:0] bsel_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      bsel <= '0;
      idx <= '0;
      digest <= 1'b0;
      second <= 1'b0;
      bsel_d <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          second <= 1'b0;
          idx <= '0;
          round <= '0;
          bsel <= '0;
          if (accept) begin
            digest <= (in_ch.mode == sha_pkg::MODE_DIGEST);
            n <= (in_ch.mode == sha_pkg::MODE_DIGEST) ? status.fill : 6'd0;
            two_blocks <= status.fill > 6'd55;
          end
        end
        S_START: begin
          round <= '0;
          bsel <= '0;
        end
        S_FETCH: begin
          if (bsel != 2'd3) begin
            bsel <= bsel + 2'd1;
          end
        end
        S_ROUND: begin
          round <= round + 7'd1;
          bsel <= '0;
        end
        S_FINISH: begin
          if (digest && two_blocks && !second) begin
            second <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            idx <= idx + 3'd1;
          end
        end
        default: ;
      endcase
      bsel_d <= bsel;
    end
  end

  // Plain compressions take the stored bytes as they are; only digest
  // passes apply the padding.
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      if (digest) begin
        gather <= {gather[15:0], pad_byte({second, round[3:0], bsel_d}, ram_rdata, n, bits,
                                          two_blocks)};
      end else begin
        gather <= {gather[15:0], ram_rdata};
      end
    end
  end

  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index = idx;
  assign out_ch.last_word = (idx == 3'd7);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while emitting");
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(idx)) else $error("index moved in stall");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> round < 7'd64) else $error("round overrun");
endmodule

>>> rtl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher.
// Input channel: mode selects append byte (0), read digest (1) or restart (2);
// data_byte is used by appends. Mode 3 is accepted and ignored.
// Output channel: eight transactions per digest read, word_index 0 first,
// last_word set on the eighth.
// Every 64th appended byte also starts a compression: sixteen word fetches
// of four bytes each from the block RAM plus 64 rounds of the shared round
// unit; the input channel waits until it ends.
// A digest read runs one or two such compressions on a copy of the chain
// hash, then presents its words; the input channel waits until all eight
// words are taken. When the receiver stalls, the current word is held.
// Reset (synchronous, rst high) loads the initial hash and clears the byte
// count; the block RAM contents are left as they are.
module sha256_stream_hasher (
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  sha_pkg::cmd_t    cmd;
  sha_pkg::status_t status;
  logic [31:0]      out_word;
  logic             ram_we;
  logic [5:0]       ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;

  sha_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_ch.data_byte),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .status(status), .out_word(out_word)
  );

  sha_controller u_ctl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .status(status),
    .out_word(out_word), .cmd(cmd), .ram_we(ram_we), .ram_waddr(ram_waddr),
    .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
  );
endmodule
